FILE: rtl/slmh_pkg.sv
// shared types and constants of the string list modular hash block
// no dependencies; imported by every rtl module of the block
package slmh_pkg;

  localparam logic [31:0] ModulusReset = 32'd1021;
  localparam logic [6:0]  HashMul      = 7'd89;
  // dividend widths for the two reductions
  localparam int unsigned ByteBits = 40;
  localparam int unsigned FoldBits = 64;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       last_in_string;
    logic       last_in_list;
  } slmh_in_t;

  typedef struct packed {
    logic [31:0] string_hash;
    logic [31:0] list_hash;
    logic        list_done;
  } slmh_out_t;

  typedef struct packed {
    logic accept;     // capture request, load byte dividend
    logic fold_mul;   // register h*a
    logic fold_load;  // load h+a+h*a as dividend
    logic div_step;   // one remainder step
    logic store_s;    // remainder -> string hash
    logic store_a;    // remainder -> list hash
    logic emit;       // write result register, clear string hash; list hash too at list end
  } slmh_cmd_t;

  typedef struct packed {
    logic present;
    logic end_str;
    logic last_step;
  } slmh_sts_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BDIV = 6'b000010,
    ST_FMUL = 6'b000100,
    ST_FADD = 6'b001000,
    ST_FDIV = 6'b010000,
    ST_EMIT = 6'b100000
  } slmh_state_e;

endpackage

FILE: rtl/slmh_ctrl.sv
// controller state machine of the string list modular hash block
// depends on slmh_pkg; drives commands to slmh_dp
module slmh_ctrl import slmh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  input  slmh_sts_t sts_i,
  output slmh_cmd_t cmd_o
);

  slmh_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  // next state after accept depends on the captured flags, chosen in the cycle after the accept
  slmh_state_e post_route;
  logic        pend_q;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !pend_q) begin
          cmd_o.accept = 1'b1;
          // fields of the request are read straight from the port here
          state_d = ST_IDLE;
        end
      end
      ST_BDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.last_step) begin
          cmd_o.store_s = 1'b1;
          state_d = sts_i.end_str ? ST_FMUL : ST_IDLE;
        end
      end
      ST_FMUL: begin
        cmd_o.fold_mul = 1'b1;
        state_d = ST_FADD;
      end
      ST_FADD: begin
        cmd_o.fold_load = 1'b1;
        state_d = ST_FDIV;
      end
      ST_FDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.last_step) begin
          cmd_o.store_a = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= cmd_o.accept;
      if (pend_q) begin
        state_q <= post_route;
      end else begin
        state_q <= state_d;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE) || pend_q;
  assign out_valid_o = out_valid_q;

  // routing once the request flags are in the datapath registers
  always_comb begin
    post_route = ST_IDLE;
    if (sts_i.present) begin
      post_route = ST_BDIV;
    end else if (sts_i.end_str) begin
      post_route = ST_FMUL;
    end
  end

endmodule

FILE: rtl/slmh_dp.sv
// datapath of the string list modular hash block: hash registers,
// multipliers and a bit-serial remainder unit; depends on slmh_pkg
module slmh_dp import slmh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  slmh_in_t    in_data_i,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  slmh_cmd_t   cmd_i,
  output slmh_sts_t   sts_o,
  output slmh_out_t   out_data_o
);

  logic [31:0] modulus_q;
  logic [31:0] s_q, a_q;
  logic        present_q, end_str_q, end_list_q;
  logic [63:0] div_q, prod_q;
  logic [31:0] rem_q;
  logic [6:0]  cnt_q;
  slmh_out_t   out_q;

  logic [32:0] n_ext;
  logic [32:0] sh;
  logic [31:0] rem_step;
  logic [39:0] byte_val;
  logic [63:0] fold_val;

  // modulus zero behaves as 2^32
  assign n_ext = {(modulus_q == 32'd0), modulus_q};
  assign sh    = {rem_q, div_q[63]};
  always_comb begin
    if (sh >= n_ext) begin
      rem_step = 32'(sh - n_ext);
    end else begin
      rem_step = sh[31:0];
    end
  end

  assign byte_val = {8'd0, s_q} + ({8'd0, s_q} * {33'd0, HashMul})
                  + {32'd0, in_data_i.char_byte};
  assign fold_val = prod_q + {32'd0, s_q} + {32'd0, a_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= ModulusReset;
      s_q        <= '0;
      a_q        <= '0;
      present_q  <= 1'b0;
      end_str_q  <= 1'b0;
      end_list_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        modulus_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        present_q  <= in_data_i.byte_present;
        end_str_q  <= in_data_i.last_in_string;
        end_list_q <= in_data_i.last_in_list;
        cnt_q      <= 7'(ByteBits);
      end
      if (cmd_i.fold_load) begin
        cnt_q <= 7'(FoldBits);
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 7'd1;
      end
      if (cmd_i.store_s) begin
        s_q <= rem_step;
      end
      if (cmd_i.store_a) begin
        a_q <= rem_step;
      end
      if (cmd_i.emit) begin
        s_q <= '0;
        if (end_list_q) begin
          a_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      div_q <= {byte_val, 24'd0};
      rem_q <= '0;
    end
    if (cmd_i.fold_mul) begin
      prod_q <= {32'd0, s_q} * {32'd0, a_q};
    end
    if (cmd_i.fold_load) begin
      div_q <= fold_val;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_q <= {div_q[62:0], 1'b0};
      rem_q <= rem_step;
    end
    if (cmd_i.emit) begin
      out_q.string_hash <= s_q;
      out_q.list_hash   <= a_q;
      out_q.list_done   <= end_list_q;
    end
  end

  assign sts_o.present   = present_q;
  assign sts_o.end_str   = end_str_q;
  assign sts_o.last_step = (cnt_q == 7'd1);
  assign out_data_o      = out_q;

endmodule

FILE: rtl/string_list_modular_hash_core.sv
// string list modular hash: one byte of a list of strings per request,
// hash of each finished string and running hash of the list
// depends on slmh_pkg, slmh_ctrl and slmh_dp
//
// input channel: in_valid_i / in_stall_o carry one slmh_in_t request; it
//   is taken on a rising edge with valid high and stall low
// output channel: out_valid_o / out_stall_i carry one slmh_out_t result for
//   every request that ends a string; the result sits in an output register
//   and holds while out_stall_i is high
// config channel: cfg_valid_i / cfg_ready_o write the modulus; ready is
//   always high, write only while the block is idle
// sequence: a request with a byte goes through capture, settle of the flags
//   and a one-bit remainder step of the bit-serial divider per bit of the
//   40-bit dividend; a string end adds the 64-bit product, the sum, a step
//   per bit of the 64-bit dividend and the load of the output register; a
//   request with neither byte nor string end has only capture and settle
// the next request is taken while a result still waits in the output
//   register; only a second result stalls until the first one is taken
// reset: modulus goes to 1021, both hashes to zero, no result pending
module string_list_modular_hash_core import slmh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  slmh_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output slmh_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  slmh_cmd_t cmd;
  slmh_sts_t sts;

  // modulus register never holds off a write
  assign cfg_ready_o = 1'b1;

  slmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slmh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
